// File: design/tpfee_pkg.sv
// Shared constants, codes and types of the two-page flash EEPROM emulator.
package tpfee_pkg;

   localparam int unsigned PAGE_HALFWORDS_DEF = 512;
   localparam int unsigned WORD_COUNT_DEF     = 128;
   localparam int unsigned REC_HW             = 3;

   localparam logic [15:0] HW_ERASED = 16'hFFFF;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_FORMAT = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_SKIPPED  = 2'd1;
   localparam logic [1:0] ST_INVALID  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic CSR_IDX_WINDOW_BASE = 1'b0;

   typedef enum logic [1:0] {
      MARK_ERASED,
      MARK_RECEIVE,
      MARK_VALID
   } mark_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WIPE0,
      S_WIPE1,
      S_SEARCH,
      S_FREE,
      S_PUT,
      S_ERASE_OTH,
      S_GATHER,
      S_EMIT,
      S_ERASE_FROM,
      S_DONE
   } state_type;

   // The active page is page 1 only when it alone carries the valid mark.
   function automatic logic pick_active(mark_type m0, mark_type m1);
      return (m1 == MARK_VALID) && (m0 != MARK_VALID);
   endfunction

endpackage

// File: design/tpfee_if.sv
// Request and response channel interfaces of the flash EEPROM emulator.
interface tpfee_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] byte_address;
   logic [15:0] write_data;

   modport source (output valid, output operation, output byte_address, output write_data,
                   input ready);
   modport sink (input valid, input operation, input byte_address, input write_data,
                 output ready);
endinterface

interface tpfee_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        found;
   logic [1:0]  status;
   logic        active_page;

   modport source (output valid, output read_data, output found, output status,
                   output active_page, input ready);
   modport sink (input valid, input read_data, input found, input status,
                 input active_page, output ready);
endinterface

// File: design/tpfee_store.sv
// Page memory and latest-value table memory, each with a registered read port.
module tpfee_store #(
   parameter int unsigned PAGE_HALFWORDS = tpfee_pkg::PAGE_HALFWORDS_DEF,
   parameter int unsigned WORD_COUNT     = tpfee_pkg::WORD_COUNT_DEF,
   localparam int unsigned IW = $clog2(PAGE_HALFWORDS),
   localparam int unsigned AW = IW + 1,
   localparam int unsigned WW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
   input  logic          clock,
   input  logic          page_we,
   input  logic [AW-1:0] page_waddr,
   input  logic [15:0]   page_wdata,
   input  logic [AW-1:0] page_raddr,
   output logic [15:0]   page_rdata,
   input  logic          tab_we,
   input  logic [WW-1:0] tab_waddr,
   input  logic [15:0]   tab_wdata,
   input  logic [WW-1:0] tab_raddr,
   output logic [15:0]   tab_rdata
);
   logic [15:0] page_mem [0:(2**AW)-1];
   logic [15:0] tab_mem  [0:WORD_COUNT-1];
   logic [15:0] page_rdata_ff;
   logic [15:0] tab_rdata_ff;

   always_ff @(posedge clock) begin
      if (page_we) begin
         page_mem[page_waddr] <= page_wdata;
      end
      page_rdata_ff <= page_mem[page_raddr];
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      tab_rdata_ff <= tab_mem[tab_raddr];
   end

   assign page_rdata = page_rdata_ff;
   assign tab_rdata  = tab_rdata_ff;
endmodule

// File: design/tpfee_seq.sv
// Sequencer: page marks, slot scanner, record writer, compaction and erase sweeps.
module tpfee_seq #(
   parameter int unsigned PAGE_HALFWORDS = tpfee_pkg::PAGE_HALFWORDS_DEF,
   parameter int unsigned WORD_COUNT     = tpfee_pkg::WORD_COUNT_DEF,
   localparam int unsigned IW = $clog2(PAGE_HALFWORDS),
   localparam int unsigned AW = IW + 1,
   localparam int unsigned WW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_operation,
   input  logic [31:0]   req_byte_address,
   input  logic [15:0]   req_write_data,
   input  logic [31:0]   window_base,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [15:0]   rsp_read_data,
   output logic          rsp_found,
   output logic [1:0]    rsp_status,
   output logic          rsp_active_page,
   output logic          page_we,
   output logic [AW-1:0] page_waddr,
   output logic [15:0]   page_wdata,
   output logic [AW-1:0] page_raddr,
   input  logic [15:0]   page_rdata,
   output logic          tab_we,
   output logic [WW-1:0] tab_waddr,
   output logic [15:0]   tab_wdata,
   output logic [WW-1:0] tab_raddr,
   input  logic [15:0]   tab_rdata
);
   import tpfee_pkg::*;

   localparam int unsigned SLOTS = (PAGE_HALFWORDS - 1) / REC_HW;
   localparam int unsigned SW    = $clog2(SLOTS + 1);
   localparam int unsigned AWC   = $clog2(WORD_COUNT + 1);
   localparam logic [IW-1:0] LAST_BASE = IW'(1 + (SLOTS - 1) * REC_HW);
   localparam logic [IW-1:0] REC_STEP  = IW'(REC_HW);
   localparam logic [IW-1:0] IDX_LAST  = IW'(PAGE_HALFWORDS - 1);

   state_type      state_ff, state_in;
   mark_type       mark_ff [2];
   mark_type       mark_in [2];
   logic [1:0]     op_ff, op_in;
   logic [15:0]    v_ff, v_in;
   logic [15:0]    data_ff, data_in;
   logic           act_ff, act_in;
   logic           fmt_ff, fmt_in;
   logic [IW-1:0]  base_ff, base_in;
   logic [1:0]     phase_ff, phase_in;
   logic [1:0]     rphase_ff, rphase_in;
   logic           rvalid_ff, rvalid_in;
   logic [15:0]    q0_ff, q1_ff;
   logic [SW-1:0]  cnt_ff, cnt_in;
   logic           pass_ff, pass_in;
   logic           pg_ff, pg_in;
   logic [IW-1:0]  put_ff, put_in;
   logic [1:0]     sub_ff, sub_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [AWC-1:0] a_ff, a_in;
   logic [SW-1:0]  n_ff, n_in;
   logic [WORD_COUNT-1:0] valid_ff;
   logic           clr_valid, set_valid;
   logic [15:0]    rd_ff, rd_in;
   logic           fnd_ff, fnd_in;
   logic [1:0]     st_ff, st_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    rsp_rd_ff, rsp_rd_in;
   logic           rsp_fnd_ff, rsp_fnd_in;
   logic [1:0]     rsp_st_ff, rsp_st_in;
   logic           rsp_act_ff, rsp_act_in;

   logic        scanning, eval, last, slot_empty, slot_ok;
   logic [31:0] offset;
   logic        addr_ok;

   assign scanning   = (state_ff == S_SEARCH) || (state_ff == S_FREE) || (state_ff == S_GATHER);
   assign eval       = scanning && rvalid_ff && (rphase_ff == 2'd2);
   assign last       = (cnt_ff == SW'(SLOTS - 1));
   assign slot_empty = (q0_ff == HW_ERASED) && (q1_ff == HW_ERASED) && (page_rdata == HW_ERASED);
   assign slot_ok    = ((q0_ff ^ q1_ff) == page_rdata);
   assign offset     = req_byte_address - window_base;
   assign addr_ok    = (req_byte_address >= window_base) && !offset[0]
                       && (offset[31:1] < 31'(WORD_COUNT));

   assign page_raddr = {pg_ff, base_ff + IW'(phase_ff)};
   assign tab_raddr  = a_ff[WW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE0;
         mark_ff[0]   <= MARK_ERASED;
         mark_ff[1]   <= MARK_ERASED;
         fmt_ff       <= 1'b0;
         idx_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         mark_ff[0]   <= mark_in[0];
         mark_ff[1]   <= mark_in[1];
         fmt_ff       <= fmt_in;
         idx_ff       <= idx_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clr_valid) begin
            valid_ff <= '0;
         end else if (set_valid) begin
            valid_ff[q0_ff[WW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      v_ff       <= v_in;
      data_ff    <= data_in;
      act_ff     <= act_in;
      base_ff    <= base_in;
      phase_ff   <= phase_in;
      rphase_ff  <= rphase_in;
      cnt_ff     <= cnt_in;
      pass_ff    <= pass_in;
      pg_ff      <= pg_in;
      put_ff     <= put_in;
      sub_ff     <= sub_in;
      a_ff       <= a_in;
      n_ff       <= n_in;
      rd_ff      <= rd_in;
      fnd_ff     <= fnd_in;
      st_ff      <= st_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_fnd_ff <= rsp_fnd_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_act_ff <= rsp_act_in;
      if (rvalid_ff && (rphase_ff == 2'd0)) begin
         q0_ff <= page_rdata;
      end
      if (rvalid_ff && (rphase_ff == 2'd1)) begin
         q1_ff <= page_rdata;
      end
   end

   always_comb begin
      logic        hit_now;
      logic [15:0] cur_now;
      logic        done_search;
      mark_type    m0;
      hit_now     = 1'b0;
      cur_now     = HW_ERASED;
      done_search = 1'b0;
      m0          = mark_ff[0];

      state_in     = state_ff;
      mark_in[0]   = mark_ff[0];
      mark_in[1]   = mark_ff[1];
      op_in        = op_ff;
      v_in         = v_ff;
      data_in      = data_ff;
      act_in       = act_ff;
      fmt_in       = fmt_ff;
      base_in      = base_ff;
      phase_in     = phase_ff;
      rphase_in    = phase_ff;
      rvalid_in    = 1'b0;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      pg_in        = pg_ff;
      put_in       = put_ff;
      sub_in       = sub_ff;
      idx_in       = idx_ff;
      a_in         = a_ff;
      n_in         = n_ff;
      rd_in        = rd_ff;
      fnd_in       = fnd_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rd_in    = rsp_rd_ff;
      rsp_fnd_in   = rsp_fnd_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_act_in   = rsp_act_ff;
      clr_valid    = 1'b0;
      set_valid    = 1'b0;
      req_ready    = 1'b0;
      page_we      = 1'b0;
      page_waddr   = '0;
      page_wdata   = HW_ERASED;
      tab_we       = 1'b0;
      tab_waddr    = q0_ff[WW-1:0];
      tab_wdata    = q1_ff;

      // The scanner streams one halfword per cycle; a slot is judged when
      // its third halfword comes back from the memory.
      if (scanning) begin
         rvalid_in = 1'b1;
         phase_in  = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
         if (phase_ff == 2'd2) begin
            base_in = (state_ff == S_SEARCH) ? base_ff - REC_STEP : base_ff + REC_STEP;
         end
         if (eval) begin
            cnt_in = cnt_ff + SW'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in   = req_operation;
               data_in = req_write_data;
               v_in    = offset[16:1];
               rd_in   = '0;
               fnd_in  = 1'b0;
               st_in   = ST_DONE;
               case (req_operation)
                  OP_FORMAT: begin
                     fmt_in   = 1'b1;
                     idx_in   = '0;
                     state_in = S_WIPE0;
                  end
                  OP_READ, OP_WRITE: begin
                     if (!addr_ok) begin
                        st_in    = ST_INVALID;
                        rd_in    = (req_operation == OP_READ) ? HW_ERASED : 16'h0000;
                        state_in = S_DONE;
                     end else begin
                        if ((mark_ff[0] == MARK_ERASED) && (mark_ff[1] == MARK_ERASED)) begin
                           m0         = MARK_VALID;
                           mark_in[0] = MARK_VALID;
                        end
                        act_in   = pick_active(m0, mark_ff[1]);
                        pg_in    = pick_active(m0, mark_ff[1]);
                        base_in  = LAST_BASE;
                        phase_in = 2'd0;
                        cnt_in   = '0;
                        pass_in  = 1'b0;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     st_in    = ST_INVALID;
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_WIPE0, S_WIPE1: begin
            page_we    = 1'b1;
            page_waddr = {(state_ff == S_WIPE1), idx_ff};
            idx_in     = idx_ff + IW'(1);
            if (idx_ff == IDX_LAST) begin
               idx_in = '0;
               if (state_ff == S_WIPE0) begin
                  state_in = S_WIPE1;
               end else if (fmt_ff) begin
                  mark_in[0] = MARK_VALID;
                  mark_in[1] = MARK_ERASED;
                  state_in   = S_DONE;
               end else begin
                  mark_in[0] = MARK_ERASED;
                  mark_in[1] = MARK_ERASED;
                  state_in   = S_IDLE;
               end
            end
         end

         S_SEARCH: begin
            if (eval) begin
               if (!slot_empty && slot_ok && (q0_ff == v_ff)) begin
                  hit_now     = 1'b1;
                  cur_now     = q1_ff;
                  done_search = 1'b1;
               end else if (last) begin
                  if (!pass_ff) begin
                     pass_in  = 1'b1;
                     pg_in    = ~act_ff;
                     base_in  = LAST_BASE;
                     phase_in = 2'd0;
                     cnt_in   = '0;
                  end else begin
                     done_search = 1'b1;
                  end
               end
            end
            if (done_search) begin
               if (op_ff == OP_READ) begin
                  rd_in    = cur_now;
                  fnd_in   = hit_now;
                  state_in = S_DONE;
               end else if (cur_now == data_ff) begin
                  st_in    = ST_SKIPPED;
                  state_in = S_DONE;
               end else begin
                  pg_in    = act_ff;
                  base_in  = IW'(1);
                  phase_in = 2'd0;
                  cnt_in   = '0;
                  state_in = S_FREE;
               end
            end
         end

         S_FREE: begin
            if (eval) begin
               if (slot_empty) begin
                  put_in   = base_ff - REC_STEP;
                  sub_in   = 2'd0;
                  state_in = S_PUT;
               end else if (last) begin
                  mark_in[~act_ff] = MARK_ERASED;
                  idx_in           = '0;
                  state_in         = S_ERASE_OTH;
               end
            end
         end

         S_PUT: begin
            page_we    = 1'b1;
            page_waddr = {act_ff, put_ff + IW'(sub_ff)};
            case (sub_ff)
               2'd0:    page_wdata = v_ff;
               2'd1:    page_wdata = data_ff;
               default: page_wdata = v_ff ^ data_ff;
            endcase
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd2) begin
               state_in = S_DONE;
            end
         end

         S_ERASE_OTH: begin
            page_we    = 1'b1;
            page_waddr = {~act_ff, idx_ff};
            idx_in     = idx_ff + IW'(1);
            if (idx_ff == IDX_LAST) begin
               clr_valid = 1'b1;
               pg_in     = act_ff;
               base_in   = IW'(1);
               phase_in  = 2'd0;
               cnt_in    = '0;
               state_in  = S_GATHER;
            end
         end

         S_GATHER: begin
            if (eval) begin
               if (!slot_empty && slot_ok && (q0_ff < 16'(WORD_COUNT))) begin
                  tab_we    = 1'b1;
                  set_valid = 1'b1;
               end
               if (last) begin
                  mark_in[~act_ff] = MARK_RECEIVE;
                  a_in             = '0;
                  n_in             = '0;
                  sub_in           = 2'd0;
                  put_in           = IW'(1);
                  state_in         = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            case (sub_ff)
               2'd0: begin
                  if (a_ff == AWC'(WORD_COUNT)) begin
                     mark_in[~act_ff] = MARK_VALID;
                     idx_in           = '0;
                     state_in         = S_ERASE_FROM;
                  end else if (!valid_ff[a_ff[WW-1:0]]) begin
                     a_in = a_ff + AWC'(1);
                  end else if (n_ff == SW'(SLOTS)) begin
                     st_in    = ST_OVERFLOW;
                     state_in = S_DONE;
                  end else begin
                     sub_in = 2'd1;
                  end
               end
               2'd1: begin
                  page_we    = 1'b1;
                  page_waddr = {~act_ff, put_ff};
                  page_wdata = 16'(a_ff);
                  sub_in     = 2'd2;
               end
               2'd2: begin
                  page_we    = 1'b1;
                  page_waddr = {~act_ff, put_ff + IW'(1)};
                  page_wdata = tab_rdata;
                  sub_in     = 2'd3;
               end
               default: begin
                  page_we    = 1'b1;
                  page_waddr = {~act_ff, put_ff + IW'(2)};
                  page_wdata = 16'(a_ff) ^ tab_rdata;
                  put_in     = put_ff + REC_STEP;
                  n_in       = n_ff + SW'(1);
                  a_in       = a_ff + AWC'(1);
                  sub_in     = 2'd0;
               end
            endcase
         end

         S_ERASE_FROM: begin
            page_we    = 1'b1;
            page_waddr = {act_ff, idx_ff};
            idx_in     = idx_ff + IW'(1);
            if (idx_ff == IDX_LAST) begin
               mark_in[act_ff] = MARK_ERASED;
               act_in          = ~act_ff;
               sub_in          = 2'd0;
               if (n_ff == SW'(SLOTS)) begin
                  st_in    = ST_OVERFLOW;
                  state_in = S_DONE;
               end else begin
                  state_in = S_PUT;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = rd_ff;
               rsp_fnd_in   = fnd_ff;
               rsp_st_in    = st_ff;
               rsp_act_in   = pick_active(mark_ff[0], mark_ff[1]);
               fmt_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_rd_ff;
   assign rsp_found       = rsp_fnd_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_active_page = rsp_act_ff;
endmodule

// File: design/two_page_flash_eeprom_emulator_top.sv
// The slot scanner reads one halfword per cycle from the read port of the page memory.
// A write that finds the active page full first compacts it into the other page.
// One request is worked on at a time; the next is taken while a response waits.
// Reset is synchronous: a clearing pass erases both pages before ready.
module two_page_flash_eeprom_emulator_top #(
   parameter int unsigned PAGE_HALFWORDS = tpfee_pkg::PAGE_HALFWORDS_DEF,
   parameter int unsigned WORD_COUNT     = tpfee_pkg::WORD_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tpfee_req_if.sink   req_ch,
   tpfee_rsp_if.source rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tpfee_pkg::*;

   localparam int unsigned IW = $clog2(PAGE_HALFWORDS);
   localparam int unsigned AW = IW + 1;
   localparam int unsigned WW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   // The window base register is the only register; it is written on the
   // access cycle of an APB write and is read back as written.
   logic [31:0] window_base_ff, window_base_in;
   logic        csr_hit;

   logic          page_we;
   logic [AW-1:0] page_waddr;
   logic [15:0]   page_wdata;
   logic [AW-1:0] page_raddr;
   logic [15:0]   page_rdata;
   logic          tab_we;
   logic [WW-1:0] tab_waddr;
   logic [15:0]   tab_wdata;
   logic [WW-1:0] tab_raddr;
   logic [15:0]   tab_rdata;

   assign csr_hit    = (csr_paddr[2] == CSR_IDX_WINDOW_BASE);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? window_base_ff : 32'h0;

   always_comb begin
      window_base_in = window_base_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         window_base_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff <= '0;
      end else begin
         window_base_ff <= window_base_in;
      end
   end

   // The page memory holds both pages side by side; the page number is the
   // top address bit. The latest-value table is only used during compaction.
   tpfee_store #(
      .PAGE_HALFWORDS(PAGE_HALFWORDS),
      .WORD_COUNT    (WORD_COUNT)
   ) u_store (
      .clock     (clock),
      .page_we   (page_we),
      .page_waddr(page_waddr),
      .page_wdata(page_wdata),
      .page_raddr(page_raddr),
      .page_rdata(page_rdata),
      .tab_we    (tab_we),
      .tab_waddr (tab_waddr),
      .tab_wdata (tab_wdata),
      .tab_raddr (tab_raddr),
      .tab_rdata (tab_rdata)
   );

   // The sequencer settles the page marks, searches, appends, compacts and
   // erases, driving the shared scanner and the single write port.
   tpfee_seq #(
      .PAGE_HALFWORDS(PAGE_HALFWORDS),
      .WORD_COUNT    (WORD_COUNT)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_operation   (req_ch.operation),
      .req_byte_address(req_ch.byte_address),
      .req_write_data  (req_ch.write_data),
      .window_base     (window_base_ff),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_read_data   (rsp_ch.read_data),
      .rsp_found       (rsp_ch.found),
      .rsp_status      (rsp_ch.status),
      .rsp_active_page (rsp_ch.active_page),
      .page_we         (page_we),
      .page_waddr      (page_waddr),
      .page_wdata      (page_wdata),
      .page_raddr      (page_raddr),
      .page_rdata      (page_rdata),
      .tab_we          (tab_we),
      .tab_waddr       (tab_waddr),
      .tab_wdata       (tab_wdata),
      .tab_raddr       (tab_raddr),
      .tab_rdata       (tab_rdata)
   );
endmodule

// File: design/tpfee_checker.sv
// Port-level checks of the flash EEPROM emulator, bound to the top level.
module tpfee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_read_data,
   input logic        rsp_found,
   input logic [1:0]  rsp_status
);
   import tpfee_pkg::*;

   // Requests are held off as the clearing pass after reset starts.
   a_busy_after_reset: assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("request accepted during the clearing pass");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_DONE))
      else $error("found flag set on a request that did not complete");

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_SKIPPED)) |-> (!rsp_found && (rsp_read_data == 16'h0)))
      else $error("skipped write carries read data");
endmodule

bind two_page_flash_eeprom_emulator_top tpfee_checker u_tpfee_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_read_data(rsp_ch.read_data),
   .rsp_found    (rsp_ch.found),
   .rsp_status   (rsp_ch.status)
);

// File: sim/two_page_flash_eeprom_emulator_top_tb.sv
// Self-checking testbench of the two-page flash EEPROM emulator top level.
module two_page_flash_eeprom_emulator_top_tb;
   import tpfee_pkg::*;

   // Operation code 3 is not defined by the block; it must be rejected.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] ADDR_WINDOW_BASE = 3'd0;
   localparam int PAGE_HW = 512;
   localparam int WORDS = 128;
   localparam int SLOT_COUNT = (PAGE_HW - 1) / 3;
   localparam logic [15:0] MK_ERASED = 16'hFFFF;
   localparam logic [15:0] MK_RECEIVE = 16'hEEEE;
   localparam logic [15:0] MK_VALID = 16'h0000;

   typedef struct packed {
      logic [15:0] read_data;
      logic        found;
      logic [1:0]  status;
      logic        active_page;
   } emu_result_type;

   // Shadow copy of the two pages plus the queue of results the block owes us.
   class flash_image_sb_type;
      logic [15:0] pages[2][PAGE_HW];
      logic [15:0] latest_val[WORDS];
      bit          latest_ok[WORDS];
      logic [31:0] window_base;
      emu_result_type owed[$];
      int          mismatches;

      function new();
         wipe(0);
         wipe(1);
         window_base = '0;
         mismatches = 0;
      endfunction

      function void wipe(int p);
         for (int i = 0; i < PAGE_HW; i++) pages[p][i] = MK_ERASED;
      endfunction

      function bit slot_blank(int p, int s);
         return pages[p][1+3*s] == MK_ERASED && pages[p][2+3*s] == MK_ERASED &&
                pages[p][3+3*s] == MK_ERASED;
      endfunction

      function int slots_used(int p);
         int s;
         s = 0;
         while (s < SLOT_COUNT && !slot_blank(p, s)) s++;
         return s;
      endfunction

      function int active_of();
         bit v0, v1;
         v0 = pages[0][0] == MK_VALID;
         v1 = pages[1][0] == MK_VALID;
         if (v0 && !v1) return 0;
         if (v1 && !v0) return 1;
         if (v0 && v1) return (slots_used(0) >= slots_used(1)) ? 0 : 1;
         return 0;
      endfunction

      function int settle_pages();
         if (pages[0][0] == MK_ERASED && pages[1][0] == MK_ERASED) pages[0][0] = MK_VALID;
         return active_of();
      endfunction

      // Newest record of the word whose check halfword matches, scanning from the last slot.
      function bit lookup(int p, logic [15:0] word, output logic [15:0] val);
         logic [15:0] a, d, c;
         val = MK_ERASED;
         for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            a = pages[p][1+3*s];
            d = pages[p][2+3*s];
            c = pages[p][3+3*s];
            if (a == 16'hFFFF && d == 16'hFFFF && c == 16'hFFFF) continue;
            if ((a ^ d) == c && a == word) begin
               val = d;
               return 1;
            end
         end
         return 0;
      endfunction

      function void put_rec(int p, int s, logic [15:0] a, logic [15:0] d);
         pages[p][1+3*s] = a;
         pages[p][2+3*s] = d;
         pages[p][3+3*s] = a ^ d;
      endfunction

      function bit append_rec(int p, logic [15:0] a, logic [15:0] d);
         int s;
         s = slots_used(p);
         if (s >= SLOT_COUNT) return 0;
         put_rec(p, s, a, d);
         return 1;
      endfunction

      // Copies the latest value of each recorded word to the other page, lowest word first.
      function bit compact_into(int from, int to);
         int n;
         logic [15:0] a, d, c;
         n = 0;
         for (int w = 0; w < WORDS; w++) latest_ok[w] = 0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            a = pages[from][1+3*s];
            d = pages[from][2+3*s];
            c = pages[from][3+3*s];
            if (a == 16'hFFFF && d == 16'hFFFF && c == 16'hFFFF) continue;
            if ((a ^ d) == c && a < WORDS) begin
               latest_val[a] = d;
               latest_ok[a] = 1;
            end
         end
         pages[to][0] = MK_RECEIVE;
         for (int w = 0; w < WORDS; w++) begin
            if (!latest_ok[w]) continue;
            if (n >= SLOT_COUNT) return 0;
            put_rec(to, n, w[15:0], latest_val[w]);
            n++;
         end
         pages[to][0] = MK_VALID;
         wipe(from);
         return 1;
      endfunction

      function void note_request(logic [1:0] op, logic [31:0] addr, logic [15:0] data);
         emu_result_type r;
         logic [31:0] off;
         logic [15:0] word, cur;
         bit hit;
         int act;
         r = '0;
         if (op == OP_FORMAT) begin
            wipe(0);
            wipe(1);
            pages[0][0] = MK_VALID;
         end else if (op == OP_UNUSED) begin
            r.status = ST_INVALID;
         end else begin
            off = addr - window_base;
            if (addr < window_base || off[0] || (off >> 1) >= WORDS) begin
               r.status = ST_INVALID;
               if (op == OP_READ) r.read_data = 16'hFFFF;
            end else begin
               word = off[16:1];
               act = settle_pages();
               hit = lookup(act, word, cur);
               if (!hit) hit = lookup(1 - act, word, cur);
               if (!hit) cur = 16'hFFFF;
               if (op == OP_READ) begin
                  r.read_data = cur;
                  r.found = hit;
               end else if (cur == data) begin
                  r.status = ST_SKIPPED;
               end else if (!append_rec(act, word, data)) begin
                  wipe(1 - act);
                  if (!compact_into(act, 1 - act)) r.status = ST_OVERFLOW;
                  else if (!append_rec(settle_pages(), word, data)) r.status = ST_OVERFLOW;
               end
            end
         end
         r.active_page = 1'(active_of());
         owed.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_result(emu_result_type got);
         emu_result_type want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected response %h", got));
            return;
         end
         want = owed.pop_front();
         if (got.read_data !== want.read_data)
            report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
         if (got.found !== want.found)
            report($sformatf("found %b, expected %b", got.found, want.found));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.active_page !== want.active_page)
            report($sformatf("active_page %b, expected %b", got.active_page, want.active_page));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   tpfee_req_if req_ch ();
   tpfee_rsp_if rsp_ch ();

   two_page_flash_eeprom_emulator_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   flash_image_sb_type sb = new();
   int sender_idle_pct;
   int receiver_idle_pct;

   // Clock with a period of two time units.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // The timeout bound is very loose compared with the time one request takes.
   initial begin
      #40000000;
      $display("FAILURE");
      $finish;
   end

   // Response side: checks each accepted response and then decides whether
   // to stall the next cycle.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.read_data, rsp_ch.found, rsp_ch.status,
                             rsp_ch.active_page});
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Drives one request, holding valid across back-to-back requests so that
   // valid never gets two assignments in the same step.
   task automatic send_request(logic [1:0] op, logic [31:0] addr, logic [15:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.byte_address <= addr;
      req_ch.write_data <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(op, addr, data);
   endtask

   // Register writes happen only while nothing is outstanding. Every request
   // produces a response, so an empty queue means the block is idle.
   task automatic write_window_base(logic [31:0] value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_WINDOW_BASE;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.window_base = value;
   endtask

   // Writes that never repeat the stored value, enough to overflow the active
   // page once so that a compaction runs.
   task automatic fill_active_page(int count);
      for (int i = 0; i < count; i++)
         send_request(OP_WRITE, sb.window_base + 32'(2 * (i % WORDS)), 16'(i + 256));
   endtask

   // Mostly well-formed reads and writes inside the window; the rest is
   // noise, bad addresses and formats.
   task automatic random_requests(int count);
      int pick;
      logic [31:0] word_addr;
      logic [15:0] data;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         word_addr = sb.window_base + 2 * $urandom_range(WORDS - 1);
         data = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
         if (pick < 5)
            send_request(2'($urandom_range(3)), $urandom, 16'($urandom));
         else if (pick < 8)
            send_request(2'($urandom_range(1)), word_addr + 1, data);
         else if (pick < 10)
            send_request(OP_WRITE, sb.window_base + 2 * WORDS, data);
         else if (pick < 11)
            send_request(OP_FORMAT, $urandom, 16'($urandom));
         else if (pick < 37)
            send_request(OP_READ, word_addr, 16'($urandom));
         else
            send_request(OP_WRITE, word_addr, data);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_READ;
      req_ch.byte_address = '0;
      req_ch.write_data = '0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty reads, skipped writes, window edges, every operation.
      send_request(OP_READ, 32'h0, 16'h0);
      send_request(OP_WRITE, 32'h0, 16'h0000);
      send_request(OP_WRITE, 32'h0, 16'h0000);
      send_request(OP_READ, 32'h0, 16'hFFFF);
      send_request(OP_WRITE, 32'd254, 16'hFFFF);
      send_request(OP_WRITE, 32'd254, 16'h1234);
      send_request(OP_READ, 32'd254, 16'h0);
      send_request(OP_WRITE, 32'd1, 16'h5555);
      send_request(OP_READ, 32'd256, 16'h0);
      send_request(OP_READ, 32'hFFFF_FFFF, 16'h0);
      send_request(OP_WRITE, 32'hFFFF_FFFE, 16'hFFFF);
      send_request(OP_UNUSED, 32'h0, 16'hAAAA);
      send_request(OP_FORMAT, 32'h0, 16'h0);
      send_request(OP_READ, 32'h0, 16'h0);
      send_request(OP_READ, 32'd254, 16'h0);

      // Fill the freshly formatted page past its last slot.
      fill_active_page(SLOT_COUNT + 5);

      // Top of the address space: only the last byte address is a valid word.
      write_window_base(32'hFFFF_FFFF);
      send_request(OP_READ, 32'hFFFF_FFFF, 16'h0);
      send_request(OP_WRITE, 32'hFFFF_FFFF, 16'hABCD);
      send_request(OP_READ, 32'hFFFF_FFFF, 16'h0);
      send_request(OP_READ, 32'h0, 16'h0);
      send_request(OP_WRITE, 32'hFFFF_FFFE, 16'h0001);

      // Random phases: sender idles lightly and receiver heavily, then the reverse, then no idling.
      write_window_base(32'h0000_1000);
      sender_idle_pct = 9;
      receiver_idle_pct = 64;
      random_requests(30);

      write_window_base(32'hFFFF_FF00);
      sender_idle_pct = 64;
      receiver_idle_pct = 9;
      random_requests(30);

      write_window_base(32'h0000_0000);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      random_requests(35);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
